// ===== hdl/sapc_pkg.sv =====
// ---------------------------------------------------------------------------
// sapc_pkg
// Shared types and constants of the sensor average / percent calibrate block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sapc_pkg;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int PCT_W    = 7;
    localparam int MODE_W   = 2;

    // mode codes carried in the input tuser
    localparam logic [MODE_W-1:0] MODE_MEASURE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WET     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DRY     = 2'd2;

    // run kind when no calibration run is active
    localparam logic [MODE_W-1:0] CAL_IDLE = 2'd0;

    // calibration limits after reset
    localparam logic [SAMPLE_W-1:0] WET_RESET  = 12'd1300;
    localparam logic [SAMPLE_W-1:0] DRY_RESET  = 12'd3400;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hFFF;

    // percent scaling
    localparam logic signed [7:0] PCT_SCALE = 8'sd100;
    localparam logic [PCT_W-1:0]  PCT_MAX   = 7'd100;

    // serial divider geometry
    localparam int DIV_W = 19;              // dividend width
    localparam int DVS_W = 12;              // divisor width
    localparam int QUO_W = 12;              // quotient width
    localparam int SH_W  = DVS_W + QUO_W;   // shifted divisor width
    localparam int CNT_W = 4;               // step counter width

    localparam logic [CNT_W-1:0] PCT_QBITS = 4'd7;

    // divider status toward the controller
    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } div_res_t;

endpackage

// ===== hdl/sapc_win.sv =====
// ---------------------------------------------------------------------------
// sapc_win
// Sample ring in a synchronous memory with a running window sum
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sapc_win #(
    parameter int WINDOW = 8,
    parameter int SUM_W  = 15
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [sapc_pkg::SAMPLE_W-1:0] sample,
    output logic [SUM_W-1:0]              sum,
    output logic                          done
);
    import sapc_pkg::*;

    localparam int PTR_W = $clog2(WINDOW);

    logic [SAMPLE_W-1:0] mem [WINDOW];
    logic [WINDOW-1:0]   vld_reg;
    logic [PTR_W-1:0]    wptr_reg;
    logic [SAMPLE_W-1:0] rd_reg;
    logic                rd_vld_reg;
    logic                pend_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic                done_reg;
    logic [SAMPLE_W-1:0] old_val;
    logic [SUM_W-1:0]    sum_next;

    // oldest entry, zero until the slot was written once
    assign old_val  = rd_vld_reg ? rd_reg : '0;
    assign sum_next = sum_reg - SUM_W'(old_val) + SUM_W'(sample);

    // memory read and write ports
    always_ff @(posedge aclk) begin
        if (start) begin
            rd_reg <= mem[wptr_reg];
        end
        if (pend_reg) begin
            mem[wptr_reg] <= sample;
        end
    end

    // pointer, valid bits and sum update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            wptr_reg <= '0;
            sum_reg  <= '0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                pend_reg   <= 1'b1;
                rd_vld_reg <= vld_reg[wptr_reg];
            end else if (pend_reg) begin
                pend_reg          <= 1'b0;
                done_reg          <= 1'b1;
                sum_reg           <= sum_next;
                vld_reg[wptr_reg] <= 1'b1;
                if (wptr_reg == PTR_W'(WINDOW - 1)) begin
                    wptr_reg <= '0;
                end else begin
                    wptr_reg <= wptr_reg + 1'b1;
                end
            end
        end
    end

    assign sum  = sum_reg;
    assign done = done_reg;

endmodule

// ===== hdl/sapc_div.sv =====
// ---------------------------------------------------------------------------
// sapc_div
// Restoring serial divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sapc_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [sapc_pkg::DIV_W-1:0] dividend,
    input  logic [sapc_pkg::DVS_W-1:0] divisor,
    input  logic [sapc_pkg::CNT_W-1:0] qbits,
    output sapc_pkg::div_res_t         res
);
    import sapc_pkg::*;

    logic [DIV_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             ovf_reg;
    logic             done_reg;
    logic [CNT_W-1:0] step_idx;
    logic [SH_W-1:0]  trial;
    logic             fits;
    logic             ovf_start;

    // trial subtrahend for the current quotient bit
    assign step_idx  = cnt_reg - 1'b1;
    assign trial     = SH_W'(dvs_reg) << step_idx;
    assign fits      = SH_W'(rem_reg) >= trial;
    // quotient would need more than qbits bits
    assign ovf_start = SH_W'(dividend) >= (SH_W'(divisor) << qbits);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg <= dividend;
                dvs_reg <= divisor;
                cnt_reg <= qbits;
                quo_reg <= '0;
                ovf_reg <= ovf_start;
            end else if (cnt_reg != '0) begin
                if (fits) begin
                    rem_reg           <= rem_reg - trial[DIV_W-1:0];
                    quo_reg[step_idx] <= 1'b1;
                end
                cnt_reg <= step_idx;
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quo  = quo_reg;

endmodule

// ===== hdl/sensor_average_percent_calibrate_unit.sv =====
// ---------------------------------------------------------------------------
// sensor_average_percent_calibrate_unit
// Moving-average moisture sensor front end with two-point percent scaling
// ---------------------------------------------------------------------------
// Input beats carry a 12-bit sample in s_tdata and a mode in s_tuser:
// measure, wet calibration or dry calibration. A measure beat enters a ring
// of WINDOW samples held in a synchronous memory; the running sum is scaled
// by a reciprocal of WINDOW and the average is mapped to percent between
// the dry and wet limits. Calibration beats track the minimum (wet) or
// maximum (dry) over CAL_SAMPLES beats and replace that limit on the last
// beat of the run. Exactly one result beat leaves on m_* per input beat.
// One beat is processed at a time. A measure beat passes through the ring
// read-modify-write and the average, the multiply by 100, the start of the
// serial divider, the divider steps for the PCT_QBITS quotient bits, the
// capture of the quotient and the load of the output register; the next
// beat is taken after that load. With equal limits the division is skipped
// and the average goes straight to the output stage. Calibration and
// ignored beats go from accept straight to the output stage. The next beat
// is taken while a result waits in the output register; if the receiver
// stalls further, a finished result holds in the unit until m_tready frees
// the output register. Reset clears the ring, the sum and any calibration
// run, and restores the default wet and dry limits; no clearing pass is
// needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_average_percent_calibrate_unit #(
    parameter int WINDOW      = 8,
    parameter int CAL_SAMPLES = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // sample[11:0], zero pad
    input  logic [1:0]  s_tuser,    // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // average[11:0], percent[18:12], percent_valid[19],
                                    // cal_done[20], cal_ok[21], zero pad
);
    import sapc_pkg::*;

    localparam int SUM_W = $clog2(4095 * WINDOW + 1);
    localparam int CC_W  = $clog2(CAL_SAMPLES + 1);

    // reciprocal scaling, exact floor division for every sum below 2**SUM_W
    localparam int     LOG_W  = $clog2(WINDOW);
    localparam int     RSH    = SUM_W + LOG_W;
    localparam int     PROD_W = 2 * SUM_W + 1;
    localparam longint RECIP  = ((longint'(1) << RSH) + longint'(WINDOW) - 1)
                                / longint'(WINDOW);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN,
        ST_MUL,
        ST_PCT_GO,
        ST_PCT,
        ST_OUT
    } state_t;

    state_t              state_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] wet_reg;
    logic [SAMPLE_W-1:0] dry_reg;
    logic [MODE_W-1:0]   cal_kind_reg;
    logic [CC_W-1:0]     cal_count_reg;
    logic [SAMPLE_W-1:0] cal_extreme_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic signed [19:0]  prod_reg;
    logic [SAMPLE_W-1:0] res_avg_reg;
    logic [PCT_W-1:0]    res_pct_reg;
    logic                res_pv_reg;
    logic                res_done_reg;
    logic                res_ok_reg;
    logic                m_tvalid_reg;
    logic [23:0]         m_tdata_reg;

    logic                accept;
    logic [MODE_W-1:0]   in_mode;
    logic [SAMPLE_W-1:0] in_sample;
    logic                win_start;
    logic [SUM_W-1:0]    win_sum;
    logic                win_done;
    logic [PROD_W-1:0]   avg_prod;
    logic [SAMPLE_W-1:0] avg_calc;
    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [DVS_W-1:0]    div_divisor;
    logic [CNT_W-1:0]    div_qbits;
    div_res_t            div_res;

    // calibration datapath
    logic                is_wet;
    logic                new_run;
    logic [SAMPLE_W-1:0] ext_base;
    logic [SAMPLE_W-1:0] ext_new;
    logic [CC_W-1:0]     cnt_inc;
    logic                run_end;
    logic [SAMPLE_W-1:0] wet_new;
    logic [SAMPLE_W-1:0] dry_new;

    // percent datapath
    logic signed [12:0]  den_s;
    logic signed [12:0]  den_abs;
    logic signed [12:0]  diff_s;
    logic signed [20:0]  prod_full;
    logic signed [19:0]  prod_abs;
    logic                q_neg;
    logic [PCT_W-1:0]    q_pct;
    logic                pct_ok;

    assign in_mode   = s_tuser;
    assign in_sample = s_tdata[SAMPLE_W-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign win_start = accept && (in_mode == MODE_MEASURE);

    // window average from the running sum
    assign avg_prod = PROD_W'(win_sum) * PROD_W'(RECIP);
    assign avg_calc = avg_prod[RSH +: SAMPLE_W];

    // min or max tracking over a calibration run
    always_comb begin
        is_wet   = (in_mode == MODE_WET);
        new_run  = (cal_kind_reg != in_mode);
        if (new_run) begin
            ext_base = is_wet ? SAMPLE_MAX : '0;
            cnt_inc  = CC_W'(1);
        end else begin
            ext_base = cal_extreme_reg;
            cnt_inc  = cal_count_reg + 1'b1;
        end
        if (is_wet) begin
            ext_new = (in_sample < ext_base) ? in_sample : ext_base;
        end else begin
            ext_new = (in_sample > ext_base) ? in_sample : ext_base;
        end
        run_end = (cnt_inc >= CC_W'(CAL_SAMPLES));
        wet_new = (run_end && is_wet)  ? ext_new : wet_reg;
        dry_new = (run_end && !is_wet) ? ext_new : dry_reg;
    end

    // signed span, offset and product for the percent mapping
    assign den_s     = $signed({1'b0, wet_reg}) - $signed({1'b0, dry_reg});
    assign den_abs   = den_s[12] ? -den_s : den_s;
    assign diff_s    = $signed({1'b0, avg_reg}) - $signed({1'b0, dry_reg});
    assign prod_full = diff_s * PCT_SCALE;
    assign prod_abs  = prod_reg[19] ? -prod_reg : prod_reg;
    assign q_neg     = prod_reg[19] ^ den_s[12];
    assign q_pct     = div_res.quo[PCT_W-1:0];
    assign pct_ok    = !div_res.ovf && ((q_pct == '0) || (!q_neg && (q_pct <= PCT_MAX)));

    // divider operands for the percent quotient
    assign div_start    = (state_reg == ST_PCT_GO);
    assign div_dividend = prod_abs[DIV_W-1:0];
    assign div_divisor  = den_abs[DVS_W-1:0];
    assign div_qbits    = PCT_QBITS;

    sapc_win #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_win (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (win_start),
        .sample  (sample_reg),
        .sum     (win_sum),
        .done    (win_done)
    );

    sapc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .qbits    (div_qbits),
        .res      (div_res)
    );

    // control sequence, calibration state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            wet_reg       <= WET_RESET;
            dry_reg       <= DRY_RESET;
            cal_kind_reg  <= CAL_IDLE;
            cal_count_reg <= '0;
            cal_extreme_reg <= '0;
        end else begin
            // result beat handshake
            if ((state_reg == ST_OUT) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        sample_reg   <= in_sample;
                        res_avg_reg  <= '0;
                        res_pct_reg  <= '0;
                        res_pv_reg   <= 1'b0;
                        res_done_reg <= 1'b0;
                        res_ok_reg   <= 1'b0;
                        case (in_mode)
                            MODE_MEASURE: begin
                                cal_kind_reg  <= CAL_IDLE;
                                cal_count_reg <= '0;
                                state_reg     <= ST_WIN;
                            end
                            MODE_WET, MODE_DRY: begin
                                wet_reg   <= wet_new;
                                dry_reg   <= dry_new;
                                state_reg <= ST_OUT;
                                if (run_end) begin
                                    res_done_reg  <= 1'b1;
                                    res_ok_reg    <= (wet_new < dry_new);
                                    cal_kind_reg  <= CAL_IDLE;
                                    cal_count_reg <= '0;
                                end else begin
                                    cal_kind_reg    <= in_mode;
                                    cal_count_reg   <= cnt_inc;
                                    cal_extreme_reg <= ext_new;
                                end
                            end
                            default: begin
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_WIN: begin
                    if (win_done) begin
                        avg_reg     <= avg_calc;
                        res_avg_reg <= avg_calc;
                        if (den_s == '0) begin
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    prod_reg  <= prod_full[19:0];
                    state_reg <= ST_PCT_GO;
                end
                ST_PCT_GO: begin
                    state_reg <= ST_PCT;
                end
                ST_PCT: begin
                    if (div_res.done) begin
                        res_pct_reg <= pct_ok ? q_pct : '0;
                        res_pv_reg  <= pct_ok;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {2'b00, res_ok_reg, res_done_reg, res_pv_reg,
                                         res_pct_reg, res_avg_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/sensor_average_percent_calibrate_unit_tb.sv =====
// ---------------------------------------------------------------------------
// sensor_average_percent_calibrate_unit_tb
// Self-checking bench for the moving-average moisture sensor unit
// ---------------------------------------------------------------------------
// Sends sample beats in measure, wet, dry and ignored mode, and predicts
// every result beat with a local model of the window ring, the percent
// mapping and the calibration runs. Covers field extremes, mode changes
// in the middle of a run, completed runs, equal limits and out-of-range
// mapping, then random runs, broken runs, measure bursts and noise under
// three back-pressure profiles. Result beats are compared field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_average_percent_calibrate_unit_tb;

    import sapc_pkg::*;

    localparam int WINDOW      = 8;
    localparam int CAL_SAMPLES = 20;
    localparam int CYCLE_LIMIT = 300000;

    // mode code the unit ignores
    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

    typedef struct {
        logic [SAMPLE_W-1:0] average;
        logic [PCT_W-1:0]    percent;
        logic                percent_valid;
        logic                cal_done;
        logic                cal_ok;
    } reading_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // sample[11:0], zero pad
    logic [1:0]  s_tuser  = '0;     // mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // average[11:0], percent[18:12], percent_valid[19],
                                    // cal_done[20], cal_ok[21], zero pad

    // model state
    logic [SAMPLE_W-1:0] ring [WINDOW];
    int                  ring_ptr;
    int                  ring_sum;
    logic [SAMPLE_W-1:0] wet_lim;
    logic [SAMPLE_W-1:0] dry_lim;
    int                  run_count;
    logic [MODE_W-1:0]   run_kind;
    logic [SAMPLE_W-1:0] run_extreme;

    reading_t expected_q[$];
    int       error_count   = 0;
    int       cycle_count   = 0;
    int       beats_counted = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    sensor_average_percent_calibrate_unit #(
        .WINDOW      (WINDOW),
        .CAL_SAMPLES (CAL_SAMPLES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // cycle counter and watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("sensor_average_percent_calibrate_unit_tb: FAIL");
        $finish;
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
        if (v < 0)
            return '0;
        if (v > int'(SAMPLE_MAX))
            return SAMPLE_MAX;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic reset_model();
        for (int i = 0; i < WINDOW; i++)
            ring[i] = '0;
        ring_ptr    = 0;
        ring_sum    = 0;
        wet_lim     = WET_RESET;
        dry_lim     = DRY_RESET;
        run_count   = 0;
        run_kind    = CAL_IDLE;
        run_extreme = '0;
    endtask

    // advances the model by one sample and returns the reading it gives
    function automatic reading_t sensor_reading(input logic [MODE_W-1:0] mode,
                                                input logic [SAMPLE_W-1:0] sample);
        reading_t r;
        int       avg;
        int       den;
        int       num;
        int       q;
        r = '{default: '0};
        if (mode == MODE_MEASURE) begin
            // ring update and running sum
            run_kind = CAL_IDLE;
            run_count = 0;
            ring_sum = ring_sum - int'(ring[ring_ptr]) + int'(sample);
            ring[ring_ptr] = sample;
            ring_ptr = (ring_ptr + 1) % WINDOW;
            avg = ring_sum / WINDOW;
            r.average = avg[SAMPLE_W-1:0];
            // two-point mapping, truncated toward zero
            den = int'(wet_lim) - int'(dry_lim);
            if (den != 0) begin
                num = (avg - int'(dry_lim)) * 100;
                q = num / den;
                if (q >= 0 && q <= 100) begin
                    r.percent = q[PCT_W-1:0];
                    r.percent_valid = 1'b1;
                end
            end
        end else if (mode == MODE_WET || mode == MODE_DRY) begin
            // a new kind of sample restarts the run
            if (run_kind != mode) begin
                run_kind = mode;
                run_count = 0;
                run_extreme = (mode == MODE_WET) ? SAMPLE_MAX : '0;
            end
            if (mode == MODE_WET) begin
                if (sample < run_extreme)
                    run_extreme = sample;
            end else begin
                if (sample > run_extreme)
                    run_extreme = sample;
            end
            run_count++;
            if (run_count >= CAL_SAMPLES) begin
                if (mode == MODE_WET)
                    wet_lim = run_extreme;
                else
                    dry_lim = run_extreme;
                r.cal_done = 1'b1;
                r.cal_ok = (wet_lim < dry_lim);
                run_kind = CAL_IDLE;
                run_count = 0;
            end
        end
        return r;
    endfunction

    // one input beat; returns at the falling edge after acceptance
    task automatic send_sample(input logic [MODE_W-1:0] mode, input logic [SAMPLE_W-1:0] sample);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0, sample};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_q.push_back(sensor_reading(mode, sample));
        if (mode != MODE_IGNORED)
            beats_counted++;
        @(negedge aclk);
    endtask

    // holds off the sender until every expected result has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        @(negedge aclk);
    endtask

    // a complete run whose extreme is exactly target, other samples spread away
    task automatic send_cal_run(input logic [MODE_W-1:0] mode, input logic [SAMPLE_W-1:0] target,
                                input int spread);
        int hit;
        int v;
        hit = $urandom_range(0, CAL_SAMPLES - 1);
        for (int i = 0; i < CAL_SAMPLES; i++) begin
            v = $urandom_range(0, spread);
            if (i == hit)
                v = 0;
            if (mode == MODE_WET)
                send_sample(mode, clamp_sample(int'(target) + v));
            else
                send_sample(mode, clamp_sample(int'(target) - v));
        end
    endtask

    // measure beats around a level
    task automatic send_measure_burst(input int level, input int jitter, input int count);
        for (int i = 0; i < count; i++)
            send_sample(MODE_MEASURE,
                        clamp_sample(level + int'($urandom_range(0, 2 * jitter)) - jitter));
    endtask

    // field extremes, ignored mode and mode changes inside a run
    task automatic test_edges();
        send_sample(MODE_MEASURE, 12'd4095);
        send_sample(MODE_MEASURE, 12'd4095);
        send_sample(MODE_MEASURE, 12'd0);
        send_sample(MODE_MEASURE, 12'd2730);
        send_sample(MODE_IGNORED, 12'd4095);
        send_sample(MODE_IGNORED, 12'd0);
        send_sample(MODE_WET, 12'd4095);
        send_sample(MODE_WET, 12'd0);
        send_sample(MODE_DRY, 12'd0);
        send_sample(MODE_DRY, 12'd4095);
        send_sample(MODE_MEASURE, 12'd1300);
        send_sample(MODE_DRY, 12'd2047);
        send_sample(MODE_WET, 12'd2048);
        send_sample(MODE_IGNORED, 12'd1365);
        send_sample(MODE_WET, 12'd1024);
    endtask

    // average below the wet limit and above the dry limit
    task automatic test_out_of_range();
        send_measure_burst(0, 0, WINDOW);
        send_measure_burst(4095, 0, WINDOW);
        send_measure_burst(2400, 40, WINDOW);
    endtask

    // completed runs, including one that can leave wet above dry
    task automatic test_cal_runs();
        send_cal_run(MODE_WET, 12'($urandom_range(200, 1500)), 600);
        send_measure_burst(2000, 300, 6);
        send_cal_run(MODE_DRY, 12'($urandom_range(2500, 4000)), 600);
        send_measure_burst(int'(wet_lim) + 100, 50, 6);
        send_cal_run(MODE_WET, 12'($urandom_range(3500, 4095)), 100);
        send_measure_burst(3600, 200, 5);
        send_cal_run(MODE_WET, 12'($urandom_range(500, 1200)), 300);
    endtask

    // dry limit driven onto the wet limit, then set to a new high value
    task automatic test_equal_limits();
        send_cal_run(MODE_DRY, wet_lim, 200);
        send_measure_burst(int'(wet_lim), 20, 5);
        send_cal_run(MODE_DRY, 12'($urandom_range(3000, 4095)), 400);
    endtask

    // random mix of runs, broken runs, measure bursts and noise
    task automatic test_random(input int n_beats);
        int stop_at;
        int lo;
        int hi;
        int len;
        logic [MODE_W-1:0] m;
        stop_at = beats_counted + n_beats;
        while (beats_counted < stop_at) begin
            lo = (wet_lim < dry_lim) ? int'(wet_lim) : int'(dry_lim);
            hi = (wet_lim < dry_lim) ? int'(dry_lim) : int'(wet_lim);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    if ($urandom_range(0, 4) == 0)
                        send_measure_burst($urandom_range(0, 4095), 2048, $urandom_range(1, 10));
                    else
                        send_measure_burst($urandom_range(0, hi - lo + 600) + lo - 300,
                                           $urandom_range(0, 80), $urandom_range(1, 14));
                end
                4: begin
                    // wet run, now and then pinned to the dry limit
                    if ($urandom_range(0, 5) == 0)
                        send_cal_run(MODE_WET, dry_lim, $urandom_range(0, 300));
                    else
                        send_cal_run(MODE_WET, 12'($urandom_range(0, 2500)),
                                     $urandom_range(0, 1500));
                end
                5: begin
                    // dry run, now and then pinned to the wet limit
                    if ($urandom_range(0, 5) == 0)
                        send_cal_run(MODE_DRY, wet_lim, $urandom_range(0, 300));
                    else
                        send_cal_run(MODE_DRY, 12'($urandom_range(1500, 4095)),
                                     $urandom_range(0, 1500));
                end
                6, 7: begin
                    // run cut short by another mode
                    m = $urandom_range(0, 1) ? MODE_WET : MODE_DRY;
                    len = $urandom_range(1, CAL_SAMPLES - 1);
                    for (int i = 0; i < len; i++)
                        send_sample(m, 12'($urandom_range(0, 4095)));
                end
                default: begin
                    len = $urandom_range(1, 3);
                    for (int i = 0; i < len; i++)
                        send_sample(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)));
                end
            endcase
        end
    endtask

    // result checking against the oldest expectation
    always @(posedge aclk) begin : check_results
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: m_tdata %h", m_tdata);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[11:0] !== want.average) begin
                    $error("average: expected %0d actual %0d", want.average, m_tdata[11:0]);
                    error_count++;
                end
                if (m_tdata[18:12] !== want.percent) begin
                    $error("percent: expected %0d actual %0d", want.percent, m_tdata[18:12]);
                    error_count++;
                end
                if (m_tdata[19] !== want.percent_valid) begin
                    $error("percent_valid: expected %0d actual %0d",
                           want.percent_valid, m_tdata[19]);
                    error_count++;
                end
                if (m_tdata[20] !== want.cal_done) begin
                    $error("cal_done: expected %0d actual %0d", want.cal_done, m_tdata[20]);
                    error_count++;
                end
                if (m_tdata[21] !== want.cal_ok) begin
                    $error("cal_ok: expected %0d actual %0d", want.cal_ok, m_tdata[21]);
                    error_count++;
                end
            end
        end
    end

    // test sequence
    initial begin
        reset_model();
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // sender idles often, receiver more often
        send_idle_pct = 33;
        recv_idle_pct = 72;
        test_edges();
        test_out_of_range();
        wait_drained();
        test_cal_runs();
        test_equal_limits();
        test_random(60);

        // roles swapped
        wait_drained();
        send_idle_pct = 72;
        recv_idle_pct = 33;
        test_random(70);

        // full rate both sides
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(70);

        s_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (60) @(posedge aclk);
        if (error_count == 0) begin
            $display("sensor_average_percent_calibrate_unit_tb: PASS");
        end else begin
            $display("sensor_average_percent_calibrate_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sapc_pkg.sv
hdl/sapc_win.sv
hdl/sapc_div.sv
hdl/sensor_average_percent_calibrate_unit.sv
tb/sensor_average_percent_calibrate_unit_tb.sv
